FILE: src/uvs_pkg.sv
// Package for the UV sphere quad generator: types, constants and shared functions.
package uvs_pkg;

  localparam int COORD_FRAC_BITS = 15;
  localparam int MAX_DIVISIONS   = 256;
  localparam int QDEPTH          = 2;

  localparam logic [8:0] SECTOR_RESET = 9'd32;
  localparam logic [8:0] STACK_RESET  = 9'd16;

  localparam logic [0:0] CFG_SECTOR_COUNT = 1'b0;
  localparam logic [0:0] CFG_STACK_COUNT  = 1'b1;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] POLY_A  = 31'd1686629713;
  localparam logic [30:0] POLY_B  = 31'd688904866;
  localparam logic [30:0] POLY_C  = 31'd76016977;

  typedef struct packed {
    logic [7:0] sector_index;
    logic [7:0] stack_index;
  } uvs_in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [17:0]        vertex_index;
    logic               out_of_range;
    logic               last_result;
  } uvs_out_t;

  typedef struct packed {
    logic [7:0]  s;
    logic [7:0]  t;
    logic [8:0]  sec;
    logic [8:0]  stk;
    logic [17:0] base;
    logic        oor;
  } uvs_job_t;

  typedef struct packed {
    logic       start;
    logic [8:0] x;
    logic [8:0] d;
    logic       sh31;
  } uvs_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] ang;
    logic [16:0] tex;
  } uvs_div_rsp_t;

  function automatic logic [8:0] clamp_count(input logic [8:0] c);
    if (c == 9'd0) return 9'd1;
    if ({4'b0, c} > 13'(MAX_DIVISIONS)) return 9'(MAX_DIVISIONS);
    return c;
  endfunction

  // Q60 magnitude to signed Q1.F field, round half away from zero, saturate positive
  function automatic logic [15:0] to_field(input logic [61:0] mag, input logic neg);
    logic [61:0] v;
    logic [61:0] sat;
    v   = (mag + (62'd1 << (59 - COORD_FRAC_BITS))) >> (60 - COORD_FRAC_BITS);
    sat = (62'd1 << COORD_FRAC_BITS) - 62'd1;
    if (v == 62'd0) return 16'd0;
    if (neg) return 16'(62'd0 - v);
    if (v > sat) return sat[15:0];
    return v[15:0];
  endfunction

  function automatic logic [1:0] idx_off(input logic [2:0] n);
    unique case (n)
      3'd0: return 2'd0;
      3'd1: return 2'd1;
      3'd2: return 2'd2;
      3'd3: return 2'd1;
      3'd4: return 2'd3;
      default: return 2'd2;
    endcase
  endfunction

endpackage

FILE: src/uvs_front.sv
// Front end: configuration registers, count clamping, range check and base index.
module uvs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  uvs_pkg::uvs_in_t  in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output uvs_pkg::uvs_job_t q_entry
);
  import uvs_pkg::*;

  logic [8:0]  sector_count_r, stack_count_r;
  logic [8:0]  sec, stk;
  logic [16:0] sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_count_r <= SECTOR_RESET;
      stack_count_r  <= STACK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SECTOR_COUNT: sector_count_r <= cfg_data;
        CFG_STACK_COUNT:  stack_count_r  <= cfg_data;
      endcase
    end
  end

  assign sec = clamp_count(sector_count_r);
  assign stk = clamp_count(stack_count_r);
  assign sum = 17'(in_data.sector_index) * 17'(stk) + 17'(in_data.stack_index);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.s    = in_data.sector_index;
    q_entry.t    = in_data.stack_index;
    q_entry.sec  = sec;
    q_entry.stk  = stk;
    q_entry.base = {sum[15:0], 2'b00};
    q_entry.oor  = ({1'b0, in_data.sector_index} >= sec) ||
                   ({1'b0, in_data.stack_index} >= stk);
  end

endmodule

FILE: src/uvs_queue.sv
// Short job queue between front and back end.
module uvs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  uvs_pkg::uvs_job_t entry,
  output logic              full,
  output logic              valid,
  output uvs_pkg::uvs_job_t head,
  input  logic              pop
);
  import uvs_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  uvs_job_t        mem [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r;

  assign full  = (count_r == (PW+1)'(QDEPTH));
  assign valid = (count_r != '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

FILE: src/uvs_div.sv
// Radix-2 serial divider giving rounded angle and texture fractions.
module uvs_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  uvs_pkg::uvs_div_req_t req,
  output uvs_pkg::uvs_div_rsp_t rsp
);
  import uvs_pkg::*;

  localparam int STEPS = 41;
  localparam logic [5:0] LAST_CNT  = 6'(STEPS - 1);
  localparam logic [5:0] CAP_CNT32 = 6'(STEPS - 1 - 16);
  localparam logic [5:0] CAP_CNT31 = 6'(STEPS - 1 - 15);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [40:0] dvd_r;
  logic [8:0]  rem_r, d_r, caprem_r;
  logic [31:0] q_r, ang_r;
  logic [16:0] capq_r, tex_r;
  logic [5:0]  capcnt_r;

  logic [9:0]  trial;
  logic        ge;
  logic [8:0]  rem_n;
  logic [31:0] q_n;
  logic [8:0]  half;

  assign trial = {rem_r, dvd_r[40]};
  assign ge    = trial >= {1'b0, d_r};
  assign rem_n = ge ? 9'(trial - {1'b0, d_r}) : trial[8:0];
  assign q_n   = {q_r[30:0], ge};
  assign half  = d_r >> 1;

  function automatic logic round_up(input logic [8:0] r, input logic [8:0] h,
                                    input logic [8:0] d);
    return ({1'b0, r} + {1'b0, h}) >= {1'b0, d};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LAST_CNT) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      cnt_r    <= '0;
      rem_r    <= '0;
      q_r      <= '0;
      d_r      <= req.d;
      dvd_r    <= req.sh31 ? {1'b0, req.x, 31'b0} : {req.x, 32'b0};
      capcnt_r <= req.sh31 ? CAP_CNT31 : CAP_CNT32;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      rem_r <= rem_n;
      q_r   <= q_n;
      dvd_r <= {dvd_r[39:0], 1'b0};
      if (cnt_r == capcnt_r) begin
        capq_r   <= q_n[16:0];
        caprem_r <= rem_n;
      end
      if (cnt_r == LAST_CNT) begin
        ang_r <= q_n + 32'(round_up(rem_n, half, d_r));
        tex_r <= capq_r + 17'(round_up(caprem_r, half, d_r));
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.ang  = ang_r;
  assign rsp.tex  = tex_r;

endmodule

FILE: src/uvs_back.sv
// Back end: sine evaluation on a shared multiplier, vertex and index sequencing.
module uvs_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  uvs_pkg::uvs_job_t     q_head,
  output logic                  q_pop,
  output uvs_pkg::uvs_div_req_t div_req,
  input  uvs_pkg::uvs_div_rsp_t div_rsp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output uvs_pkg::uvs_out_t     out_data
);
  import uvs_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DSTART = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_SIN    = 3'd3;
  localparam logic [2:0] ST_VTX    = 3'd4;
  localparam logic [2:0] ST_IDX    = 3'd5;
  localparam logic [2:0] ST_OOR    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] sub_r, sub_nxt;

  uvs_job_t    job_r;
  logic [31:0] ang_r [4];
  logic [16:0] tex_i_r [2];
  logic [16:0] tex_j_r [2];
  logic [30:0] si_r [2], ci_r [2], sj_r [2], cj_r [2];
  logic [1:0]  si_n_r, ci_n_r, sj_n_r, cj_n_r;
  logic [61:0] prod_r;
  logic [30:0] x_r, x2_r;
  logic [15:0] px_r;

  logic        out_valid_r;
  uvs_out_t    out_r, out_nxt;
  logic        out_free, out_load;

  logic [31:0] ang_sel;
  logic [30:0] x_in;
  logic [30:0] mul_a, mul_b;
  logic [61:0] mul_p;
  logic        mul_en;
  logic [31:0] r_raw;
  logic [30:0] r_mag;
  logic        ia, ja;
  logic [30:0] sp, cp, st, ct;
  logic        nsp, ncp, nst, nct;
  logic [1:0]  dk;

  assign out_free = !out_valid_r || !out_stall;

  assign ang_sel = ang_r[cnt_r[2:1]] + (cnt_r[0] ? 32'h4000_0000 : 32'h0);
  assign x_in    = ang_sel[30] ? (Q30_ONE - {1'b0, ang_sel[29:0]}) : {1'b0, ang_sel[29:0]};
  assign r_raw   = prod_r[61:30];
  assign r_mag   = (r_raw > {1'b0, Q30_ONE}) ? Q30_ONE : r_raw[30:0];
  assign mul_p   = mul_a * mul_b;

  assign ia  = cnt_r[0];
  assign ja  = cnt_r[1];
  assign sp  = sj_r[ja];
  assign cp  = cj_r[ja];
  assign st  = si_r[ia];
  assign ct  = ci_r[ia];
  assign nsp = sj_n_r[ja];
  assign ncp = cj_n_r[ja];
  assign nst = si_n_r[ia];
  assign nct = ci_n_r[ia];

  assign dk = cnt_r[1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sub_nxt       = sub_r;
    q_pop         = 1'b0;
    div_req.start = 1'b0;
    div_req.x     = {1'b0, dk[1] ? job_r.t : job_r.s} + 9'(dk[0]);
    div_req.d     = dk[1] ? job_r.stk : job_r.sec;
    div_req.sh31  = dk[1];
    out_load      = 1'b0;
    out_nxt       = '0;
    mul_a         = '0;
    mul_b         = '0;
    mul_en        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cnt_nxt   = '0;
          sub_nxt   = '0;
          state_nxt = q_head.oor ? ST_OOR : ST_DSTART;
        end
      end
      ST_DSTART: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (cnt_r == 3'd3) begin
            cnt_nxt   = '0;
            state_nxt = ST_SIN;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = ST_DSTART;
          end
        end
      end
      ST_SIN: begin
        mul_en  = (sub_r != 3'd4);
        sub_nxt = sub_r + 3'd1;
        unique case (sub_r)
          3'd0: begin mul_a = x_in;        mul_b = x_in; end
          3'd1: begin mul_a = POLY_C;      mul_b = prod_r[60:30]; end
          3'd2: begin mul_a = x2_r;        mul_b = POLY_B - prod_r[60:30]; end
          3'd3: begin mul_a = x_r;         mul_b = POLY_A - prod_r[60:30]; end
          default: begin
            sub_nxt = '0;
            if (cnt_r == 3'd7) begin
              cnt_nxt   = '0;
              state_nxt = ST_VTX;
            end else begin
              cnt_nxt = cnt_r + 3'd1;
            end
          end
        endcase
      end
      ST_VTX: begin
        unique case (sub_r)
          3'd0: begin
            mul_en = 1'b1; mul_a = sp; mul_b = ct; sub_nxt = 3'd1;
          end
          3'd1: begin
            mul_en = 1'b1; mul_a = sp; mul_b = st; sub_nxt = 3'd2;
          end
          default: begin
            if (out_free) begin
              out_load             = 1'b1;
              out_nxt.result_kind  = KIND_VERTEX;
              out_nxt.pos_x        = $signed(px_r);
              out_nxt.pos_y        = $signed(to_field({1'b0, cp, 30'b0}, ncp));
              out_nxt.pos_z        = $signed(to_field(prod_r, nsp ^ nst));
              if (sp != '0) begin
                out_nxt.tangent_x  = $signed(to_field({1'b0, st, 30'b0}, !nst ^ nsp));
                out_nxt.tangent_z  = $signed(to_field({1'b0, ct, 30'b0}, nct ^ nsp));
              end
              out_nxt.tex_u        = tex_i_r[ia];
              out_nxt.tex_v        = tex_j_r[ja];
              out_nxt.vertex_index = job_r.base + 18'(cnt_r[1:0]);
              sub_nxt              = '0;
              if (cnt_r == 3'd3) begin
                cnt_nxt   = '0;
                state_nxt = ST_IDX;
              end else begin
                cnt_nxt = cnt_r + 3'd1;
              end
            end
          end
        endcase
      end
      ST_IDX: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.result_kind  = KIND_INDEX;
          out_nxt.vertex_index = job_r.base + 18'(idx_off(cnt_r));
          out_nxt.last_result  = (cnt_r == 3'd5);
          if (cnt_r == 3'd5) state_nxt = ST_IDLE;
          else cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_OOR: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.out_of_range = 1'b1;
          out_nxt.last_result  = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sub_r   <= sub_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_head;
    if (out_load) out_r <= out_nxt;
    if (mul_en) prod_r <= mul_p;
    if (state_r == ST_DIV && div_rsp.done) begin
      ang_r[dk] <= div_rsp.ang;
      if (dk[1]) tex_j_r[dk[0]] <= div_rsp.tex;
      else tex_i_r[dk[0]] <= div_rsp.tex;
    end
    if (state_r == ST_SIN && sub_r == 3'd0) x_r <= x_in;
    if (state_r == ST_SIN && sub_r == 3'd1) x2_r <= prod_r[60:30];
    if (state_r == ST_SIN && sub_r == 3'd4) begin
      unique case ({cnt_r[2], cnt_r[0]})
        2'b00: begin si_r[cnt_r[1]] <= r_mag; si_n_r[cnt_r[1]] <= ang_sel[31]; end
        2'b01: begin ci_r[cnt_r[1]] <= r_mag; ci_n_r[cnt_r[1]] <= ang_sel[31]; end
        2'b10: begin sj_r[cnt_r[1]] <= r_mag; sj_n_r[cnt_r[1]] <= ang_sel[31]; end
        default: begin cj_r[cnt_r[1]] <= r_mag; cj_n_r[cnt_r[1]] <= ang_sel[31]; end
      endcase
    end
    if (state_r == ST_VTX && sub_r == 3'd1) px_r <= to_field(prod_r, nsp ^ nct);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider result outside division wait");

  a_pop_next: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_DSTART || state_r == ST_OOR))
    else $error("job pop did not start processing");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDX && cnt_r == 3'd5 && out_free) |=> out_valid_r && out_r.last_result)
    else $error("final index result not marked last");

  a_oor_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.out_of_range) |-> out_r.last_result)
    else $error("flagged result not marked last");

endmodule

FILE: src/uv_sphere_quad_generator.sv
// Top level of the UV sphere quad generator.
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   uvs_in_t  (sector_index, stack_index)
//  out_     output     out_valid/out_stall uvs_out_t (vertex or index result)
//  cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data (9-bit count)
//
// An in-range quad takes four 41-step serial divisions for the angles and texture
// fractions, eight sine evaluations and two products per vertex on the one shared
// multiplier, then gives one index result per cycle while out_stall is low.
// An out-of-range quad gives a single flagged result, without any division.
// Reset is synchronous and active low; counts return to 32 sectors and 16 stacks.
// A two-entry queue lets the front take new quads while the back works or stalls.
module uv_sphere_quad_generator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  uvs_pkg::uvs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output uvs_pkg::uvs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [8:0]        cfg_data
);
  import uvs_pkg::*;

  logic         q_full, q_push, q_valid, q_pop;
  uvs_job_t     q_entry, q_head;
  uvs_div_req_t div_req;
  uvs_div_rsp_t div_rsp;

  uvs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .q_full, .q_push, .q_entry
  );

  uvs_queue u_queue (
    .clk, .rst_n, .push(q_push), .entry(q_entry), .full(q_full),
    .valid(q_valid), .head(q_head), .pop(q_pop)
  );

  uvs_div u_div (
    .clk, .rst_n, .req(div_req), .rsp(div_rsp)
  );

  uvs_back u_back (
    .clk, .rst_n, .q_valid, .q_head, .q_pop, .div_req, .div_rsp,
    .out_valid, .out_stall, .out_data
  );

endmodule

FILE: tb/testbench.sv
// Testbench for the UV sphere quad generator: checks every result against a built-in predictor.
`timescale 1ns / 100ps

module testbench;
  import uvs_pkg::*;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  uvs_in_t    in_data;
  logic       out_valid;
  logic       out_stall;
  uvs_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [0:0] cfg_index;
  logic [8:0] cfg_data;

  uvs_in_t  quads_pending[$];
  uvs_out_t quad_results_q[$];
  logic [8:0] sectors_reg;
  logic [8:0] stacks_reg;
  int idle_mode;
  int errors;
  int hold_cycles;
  logic start_hold;

  uv_sphere_quad_generator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] round_div(input logic [63:0] n, input logic [63:0] d);
    return (n + d / 2) / d;
  endfunction

  function automatic logic [63:0] sine_q30(input logic [31:0] ang, output logic neg);
    logic [63:0] x, x2, q, p, r;
    x = {34'd0, ang[29:0]};
    if (ang[30]) x = 64'd1073741824 - x;
    neg = ang[31];
    x2 = (x * x) >> 30;
    q = 64'(POLY_B) - ((64'(POLY_C) * x2) >> 30);
    p = 64'(POLY_A) - ((x2 * q) >> 30);
    r = (x * p) >> 30;
    if (r > 64'd1073741824) r = 64'd1073741824;
    return r;
  endfunction

  function automatic logic [15:0] q15_field(input logic [63:0] m, input logic neg);
    logic [63:0] v;
    v = (m + (64'd1 << (59 - COORD_FRAC_BITS))) >> (60 - COORD_FRAC_BITS);
    if (v == 0) return 16'd0;
    if (neg) return 16'(64'd0 - v);
    if (v > (64'd1 << COORD_FRAC_BITS) - 1) v = (64'd1 << COORD_FRAC_BITS) - 1;
    return v[15:0];
  endfunction

  function automatic uvs_out_t corner_vertex(input logic [63:0] i, input logic [63:0] j,
                                             input logic [63:0] sec, input logic [63:0] stk,
                                             input logic [63:0] vidx);
    uvs_out_t o;
    logic [31:0] th, ph;
    logic [63:0] st, ct, sp, cp;
    logic nst, nct, nsp, ncp;
    th = 32'(round_div(i << 32, sec));
    ph = 32'(round_div(j << 31, stk));
    st = sine_q30(th, nst);
    ct = sine_q30(th + 32'h4000_0000, nct);
    sp = sine_q30(ph, nsp);
    cp = sine_q30(ph + 32'h4000_0000, ncp);
    o = '0;
    o.result_kind = KIND_VERTEX;
    o.pos_x = q15_field(sp * ct, nsp != nct);
    o.pos_y = q15_field(cp << 30, ncp);
    o.pos_z = q15_field(sp * st, nsp != nst);
    if (sp != 0) begin
      o.tangent_x = q15_field(st << 30, (!nst) != nsp);
      o.tangent_z = q15_field(ct << 30, nct != nsp);
    end
    o.tex_u = 17'(round_div(i << 16, sec));
    o.tex_v = 17'(round_div(j << 16, stk));
    o.vertex_index = 18'(vidx);
    return o;
  endfunction

  function automatic logic [63:0] eff_count(input logic [8:0] c);
    if (c == 0) return 64'd1;
    if (c > MAX_DIVISIONS) return 64'(MAX_DIVISIONS);
    return 64'(c);
  endfunction

  task automatic predict_quad(input uvs_in_t q);
    logic [63:0] sec, stk, s, t, base;
    uvs_out_t o;
    sec = eff_count(sectors_reg);
    stk = eff_count(stacks_reg);
    s = 64'(q.sector_index);
    t = 64'(q.stack_index);
    if (s >= sec || t >= stk) begin
      o = '0;
      o.out_of_range = 1'b1;
      o.last_result = 1'b1;
      quad_results_q.insert(quad_results_q.size(), o);
    end else begin
      base = 4 * (s * stk + t);
      quad_results_q.insert(quad_results_q.size(), corner_vertex(s, t, sec, stk, base));
      quad_results_q.insert(quad_results_q.size(),
                            corner_vertex(s + 1, t, sec, stk, base + 1));
      quad_results_q.insert(quad_results_q.size(),
                            corner_vertex(s, t + 1, sec, stk, base + 2));
      quad_results_q.insert(quad_results_q.size(),
                            corner_vertex(s + 1, t + 1, sec, stk, base + 3));
      for (int k = 0; k < 6; k++) begin
        o = '0;
        o.result_kind = KIND_INDEX;
        o.vertex_index = 18'(base + idx_off(3'(k)));
        o.last_result = (k == 5);
        quad_results_q.insert(quad_results_q.size(), o);
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) predict_quad(in_data);
      if (!in_valid || !in_stall) begin
        if (quads_pending.size() > 0 &&
            !((idle_mode == IDLE_SEND && $urandom_range(99) < 86) ||
              (idle_mode == IDLE_BOTH && $urandom_range(99) < 10))) begin
          in_data <= quads_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) hold_cycles <= 0;
    else if (start_hold) hold_cycles <= 3000;
    else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  task automatic field_chk(input string name, input logic [17:0] e, input logic [17:0] g,
                           inout bit bad);
    if (e !== g) begin
      bad = 1'b1;
      if (errors < 10) $display("mismatch %s: expected %0h got %0h", name, e, g);
    end
  endtask

  // receiver and checker
  always @(posedge clk) begin
    uvs_out_t e;
    bit bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (quad_results_q.size() == 0) begin
          if (errors < 10) $display("unexpected result transaction %p", out_data);
          errors <= errors + 1;
        end else begin
          e = quad_results_q.pop_front();
          bad = 1'b0;
          field_chk("result_kind", 18'(e.result_kind), 18'(out_data.result_kind), bad);
          field_chk("pos_x", 18'(e.pos_x), 18'(out_data.pos_x), bad);
          field_chk("pos_y", 18'(e.pos_y), 18'(out_data.pos_y), bad);
          field_chk("pos_z", 18'(e.pos_z), 18'(out_data.pos_z), bad);
          field_chk("tangent_x", 18'(e.tangent_x), 18'(out_data.tangent_x), bad);
          field_chk("tangent_z", 18'(e.tangent_z), 18'(out_data.tangent_z), bad);
          field_chk("tex_u", 18'(e.tex_u), 18'(out_data.tex_u), bad);
          field_chk("tex_v", 18'(e.tex_v), 18'(out_data.tex_v), bad);
          field_chk("vertex_index", e.vertex_index, out_data.vertex_index, bad);
          field_chk("out_of_range", 18'(e.out_of_range), 18'(out_data.out_of_range), bad);
          field_chk("last_result", 18'(e.last_result), 18'(out_data.last_result), bad);
          if (bad) errors <= errors + 1;
        end
      end
      out_stall <= (hold_cycles > 0) ||
                   (idle_mode == IDLE_RECV && $urandom_range(99) < 86) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(99) < 10);
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (quads_pending.size() > 0 || in_valid || quad_results_q.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(input logic [0:0] idx, input logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_SECTOR_COUNT) sectors_reg = val;
    else sectors_reg = sectors_reg;
    if (idx == CFG_STACK_COUNT) stacks_reg = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_quad(input int s, input int t);
    uvs_in_t q;
    q.sector_index = 8'(s);
    q.stack_index = 8'(t);
    quads_pending.insert(quads_pending.size(), q);
  endtask

  task automatic random_phase(input logic [8:0] sec, input logic [8:0] stk, input int mode,
                              input int count);
    int se, st;
    write_count(CFG_SECTOR_COUNT, sec);
    write_count(CFG_STACK_COUNT, stk);
    idle_mode = mode;
    se = int'(eff_count(sec));
    st = int'(eff_count(stk));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) send_quad($urandom_range(255), $urandom_range(255));
      else send_quad($urandom_range(se - 1), $urandom_range(st - 1));
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SECTOR_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    start_hold = 1'b0;
    errors = 0;
    idle_mode = IDLE_NONE;
    sectors_reg = SECTOR_RESET;
    stacks_reg = STACK_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset counts
    send_quad(0, 0); send_quad(31, 15); send_quad(0, 15); send_quad(31, 0);
    send_quad(32, 0); send_quad(0, 16); send_quad(255, 255); send_quad(7, 8);
    wait_drained();
    write_count(CFG_SECTOR_COUNT, 9'd1);
    write_count(CFG_STACK_COUNT, 9'd1);
    send_quad(0, 0); send_quad(1, 0); send_quad(0, 1);
    wait_drained();
    write_count(CFG_SECTOR_COUNT, 9'd256);
    write_count(CFG_STACK_COUNT, 9'd256);
    send_quad(255, 255); send_quad(0, 0); send_quad(128, 128); send_quad(255, 0);
    wait_drained();
    // zero acts as one, above the maximum clamps
    write_count(CFG_SECTOR_COUNT, 9'd0);
    write_count(CFG_STACK_COUNT, 9'd511);
    send_quad(0, 255); send_quad(1, 0); send_quad(0, 200);
    wait_drained();

    random_phase(9'd256, 9'd256, IDLE_NONE, 48);

    write_count(CFG_SECTOR_COUNT, 9'($urandom_range(1, 256)));
    write_count(CFG_STACK_COUNT, 9'($urandom_range(1, 256)));
    idle_mode = IDLE_SEND;
    for (int n = 0; n < 24; n++)
      send_quad($urandom_range(int'(eff_count(sectors_reg)) - 1),
                $urandom_range(int'(eff_count(stacks_reg)) - 1));
    wait_drained();
    for (int n = 0; n < 24; n++)
      send_quad($urandom_range(255), $urandom_range(int'(eff_count(stacks_reg)) - 1));
    wait_drained();

    // receiver holds off while quads keep coming
    write_count(CFG_SECTOR_COUNT, 9'd256);
    write_count(CFG_STACK_COUNT, 9'($urandom_range(2, 12)));
    idle_mode = IDLE_RECV;
    @(posedge clk);
    start_hold <= 1'b1;
    @(posedge clk);
    start_hold <= 1'b0;
    for (int n = 0; n < 48; n++)
      send_quad($urandom_range(255), $urandom_range(int'(eff_count(stacks_reg)) - 1));
    wait_drained();

    random_phase(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)), IDLE_BOTH, 48);

    repeat (300) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #1500000;
    $display("Some tests failed");
    $finish;
  end

endmodule
